FILE: hdl/tgq_pkg.sv
// Shared request codes, status codes and free-list control types for the team queue.
package tgq_pkg;

   localparam logic [1:0] REQ_ASSIGN  = 2'd0;
   localparam logic [1:0] REQ_ENQUEUE = 2'd1;
   localparam logic [1:0] REQ_DEQUEUE = 2'd2;

   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_EMPTY   = 2'd1;
   localparam logic [1:0] STAT_NO_NODE = 2'd2;

   localparam int ID_W = 10;

   typedef struct packed {
      logic peek;
      logic pop;
      logic push;
   } tgq_free_cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } tgq_free_stat_type;

endpackage

FILE: hdl/team_grouped_queue.sv
// Top level of the team queue: request sequencer, team/node/ring memories and free list.
//
// Usage: a transaction is offered on start with req_type, req_element_id and
// req_team_id, and is taken at a rising edge where start is high and busy is low.
// Each transaction yields exactly one result, shown for one cycle with rsp_strobe
// high on rsp_out_valid, rsp_out_element and rsp_status. The receiver cannot hold
// results off; the result must be captured in that cycle.
// Steps from the accepting edge to the result cycle:
//   assign, unused type, ignored or rejected requests : registered result, no memory walk
//   enqueue : element-to-team read, team record read, write back
//   dequeue : order ring read, team record read, node read, head update
// busy stays high while an enqueue or dequeue walks its memory chain, and drops
// in the cycle its result is shown, so a new transaction can be taken then.
// An enqueue or dequeue holds off the next transaction until its chain of
// registered memory reads is done; other requests can be taken back to back.
// After reset the block runs a clearing pass over all team records, with busy
// high, before it takes the first transaction.
module team_grouped_queue import tgq_pkg::*; #(
   parameter int ELEMENTS = 1024,
   parameter int TEAMS    = 1024,
   parameter int CAPACITY = 1024
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  logic [1:0]      req_type,
   input  logic [ID_W-1:0] req_element_id,
   input  logic [ID_W-1:0] req_team_id,
   output logic            rsp_strobe,
   output logic            rsp_out_valid,
   output logic [ID_W-1:0] rsp_out_element,
   output logic [1:0]      rsp_status
);

   localparam int EW  = $clog2(ELEMENTS);
   localparam int TW  = (TEAMS > 1) ? $clog2(TEAMS) : 1;
   localparam int NW  = $clog2(CAPACITY);
   localparam int EIW = (EW > ID_W) ? EW : ID_W;
   localparam int TIW = (TW > ID_W) ? TW : ID_W;
   // team record: waiting flag, head node, tail node
   localparam int TMW = 1 + 2 * NW;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ENQ_TEAM,
      ST_ENQ_COMMIT,
      ST_DEQ_TEAM,
      ST_DEQ_NODE,
      ST_DEQ_DONE
   } state_type;

   state_type       state_ff, state_in;
   logic [TW-1:0]   clr_cnt_ff, clr_cnt_in;
   logic [ID_W-1:0] elem_ff, elem_in;
   logic [TW-1:0]   team_ff, team_in;
   logic [NW-1:0]   tail_ff, tail_in;
   logic            last_ff, last_in;
   logic [TW-1:0]   order_head_ff, order_head_in;
   logic [TW-1:0]   order_tail_ff, order_tail_in;
   logic [TW:0]     order_count_ff, order_count_in;
   logic            rsp_strobe_ff, rsp_strobe_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0] rsp_element_ff, rsp_element_in;
   logic [1:0]      rsp_status_ff, rsp_status_in;

   // request decode
   logic            accept;
   logic            elem_ok, team_ok;
   logic [EIW-1:0]  elem_wide;
   logic [TIW-1:0]  team_wide;
   logic [EW-1:0]   elem_idx;
   logic [TW-1:0]   team_idx;

   // memory ports
   logic            toe_we, toe_re;
   logic [TW-1:0]   toe_rdata;
   logic            tm_we, tm_re;
   logic [TW-1:0]   tm_waddr, tm_raddr;
   logic [TMW-1:0]  tm_wdata, tm_rdata;
   logic            ring_we, ring_re;
   logic [TW-1:0]   ring_rdata;
   logic            nval_we, nval_re;
   logic [ID_W-1:0] nval_rdata;
   logic            nnext_we, nnext_re;
   logic [NW-1:0]   nnext_waddr, nnext_wdata, nnext_rdata;
   logic [NW-1:0]   node_raddr;

   tgq_free_cmd_type  fl_cmd;
   tgq_free_stat_type fl_stat;
   logic [NW-1:0]     fl_node;
   logic [NW-1:0]     fl_push_node;

   // fields of the team record read back
   logic            tm_waiting;
   logic [NW-1:0]   tm_head, tm_tail;
   logic [TW-1:0]   toe_team, ring_team;

   assign busy            = (state_ff != ST_IDLE);
   assign accept          = start && (state_ff == ST_IDLE);
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_out_valid   = rsp_valid_ff;
   assign rsp_out_element = rsp_element_ff;
   assign rsp_status      = rsp_status_ff;

   assign elem_ok   = (32'(req_element_id) < 32'(ELEMENTS));
   assign team_ok   = (32'(req_team_id) < 32'(TEAMS));
   assign elem_wide = EIW'(req_element_id);
   assign team_wide = TIW'(req_team_id);
   assign elem_idx  = elem_wide[EW-1:0];
   assign team_idx  = team_wide[TW-1:0];

   assign tm_waiting = tm_rdata[TMW-1];
   assign tm_head    = tm_rdata[2*NW-1:NW];
   assign tm_tail    = tm_rdata[NW-1:0];

   // fold a team number outside the table onto team 0
   assign toe_team  = ({1'b0, toe_rdata} >= (TW+1)'(TEAMS)) ? '0 : toe_rdata;
   assign ring_team = ({1'b0, ring_rdata} >= (TW+1)'(TEAMS)) ? '0 : ring_rdata;

   always_comb begin
      state_in       = state_ff;
      clr_cnt_in     = clr_cnt_ff;
      elem_in        = elem_ff;
      team_in        = team_ff;
      tail_in        = tail_ff;
      last_in        = last_ff;
      order_head_in  = order_head_ff;
      order_tail_in  = order_tail_ff;
      order_count_in = order_count_ff;
      rsp_strobe_in  = 1'b0;
      rsp_valid_in   = 1'b0;
      rsp_element_in = '0;
      rsp_status_in  = STAT_OK;

      toe_we       = 1'b0;
      toe_re       = 1'b0;
      tm_we        = 1'b0;
      tm_re        = 1'b0;
      tm_waddr     = team_ff;
      tm_raddr     = team_ff;
      tm_wdata     = '0;
      ring_we      = 1'b0;
      ring_re      = 1'b0;
      nval_we      = 1'b0;
      nval_re      = 1'b0;
      nnext_we     = 1'b0;
      nnext_re     = 1'b0;
      nnext_waddr  = tm_tail;
      nnext_wdata  = fl_node;
      node_raddr   = tm_head;
      fl_cmd       = '0;
      fl_push_node = tm_head;

      case (state_ff)
         ST_CLEAR: begin
            // sweep the team records, dropping every waiting flag
            tm_we    = 1'b1;
            tm_waddr = clr_cnt_ff;
            tm_wdata = '0;
            if (clr_cnt_ff == TW'(TEAMS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + TW'(1);
            end
         end

         ST_IDLE: begin
            if (accept) begin
               elem_in = req_element_id;
               case (req_type)
                  REQ_ASSIGN: begin
                     toe_we        = elem_ok && team_ok;
                     rsp_strobe_in = 1'b1;
                  end
                  REQ_ENQUEUE: begin
                     if (!elem_ok) begin
                        rsp_strobe_in = 1'b1;
                     end else if (fl_stat.empty) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = STAT_NO_NODE;
                     end else begin
                        toe_re      = 1'b1;
                        fl_cmd.peek = 1'b1;
                        state_in    = ST_ENQ_TEAM;
                     end
                  end
                  REQ_DEQUEUE: begin
                     if (order_count_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        ring_re  = 1'b1;
                        state_in = ST_DEQ_TEAM;
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end

         ST_ENQ_TEAM: begin
            team_in  = toe_team;
            tm_re    = 1'b1;
            tm_raddr = toe_team;
            state_in = ST_ENQ_COMMIT;
         end

         ST_ENQ_COMMIT: begin
            // link the new node behind the team's tail, or open the team
            nval_we    = 1'b1;
            fl_cmd.pop = 1'b1;
            nnext_we   = tm_waiting;
            tm_we      = 1'b1;
            tm_wdata   = {1'b1, (tm_waiting ? tm_head : fl_node), fl_node};
            if (!tm_waiting && (order_count_ff != (TW+1)'(TEAMS))) begin
               ring_we        = 1'b1;
               order_tail_in  = (order_tail_ff == TW'(TEAMS - 1)) ?
                                '0 : order_tail_ff + TW'(1);
               order_count_in = order_count_ff + (TW+1)'(1);
            end
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
         end

         ST_DEQ_TEAM: begin
            team_in  = ring_team;
            tm_re    = 1'b1;
            tm_raddr = ring_team;
            state_in = ST_DEQ_NODE;
         end

         ST_DEQ_NODE: begin
            tail_in     = tm_tail;
            last_in     = (tm_head == tm_tail);
            nval_re     = 1'b1;
            nnext_re    = 1'b1;
            fl_cmd.push = 1'b1;
            if (tm_head == tm_tail) begin
               // team drained: retire it from the order ring
               tm_we          = 1'b1;
               tm_wdata       = {1'b0, tm_head, tm_tail};
               order_head_in  = (order_head_ff == TW'(TEAMS - 1)) ?
                                '0 : order_head_ff + TW'(1);
               order_count_in = order_count_ff - (TW+1)'(1);
            end
            state_in = ST_DEQ_DONE;
         end

         ST_DEQ_DONE: begin
            if (!last_ff) begin
               tm_we    = 1'b1;
               tm_wdata = {1'b1, nnext_rdata, tail_ff};
            end
            rsp_strobe_in  = 1'b1;
            rsp_valid_in   = 1'b1;
            rsp_element_in = nval_rdata;
            state_in       = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   tgq_ram #(
      .DEPTH (ELEMENTS),
      .WIDTH (TW)
   ) u_team_of_elem (
      .clock   (clock),
      .wr_en   (toe_we),
      .wr_addr (elem_idx),
      .wr_data (team_idx),
      .rd_en   (toe_re),
      .rd_addr (elem_idx),
      .rd_data (toe_rdata)
   );

   tgq_ram #(
      .DEPTH (TEAMS),
      .WIDTH (TMW)
   ) u_team_rec (
      .clock   (clock),
      .wr_en   (tm_we),
      .wr_addr (tm_waddr),
      .wr_data (tm_wdata),
      .rd_en   (tm_re),
      .rd_addr (tm_raddr),
      .rd_data (tm_rdata)
   );

   tgq_ram #(
      .DEPTH (TEAMS),
      .WIDTH (TW)
   ) u_order_ring (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (order_tail_ff),
      .wr_data (team_ff),
      .rd_en   (ring_re),
      .rd_addr (order_head_ff),
      .rd_data (ring_rdata)
   );

   tgq_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (ID_W)
   ) u_node_value (
      .clock   (clock),
      .wr_en   (nval_we),
      .wr_addr (fl_node),
      .wr_data (elem_ff),
      .rd_en   (nval_re),
      .rd_addr (node_raddr),
      .rd_data (nval_rdata)
   );

   tgq_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (NW)
   ) u_node_next (
      .clock   (clock),
      .wr_en   (nnext_we),
      .wr_addr (nnext_waddr),
      .wr_data (nnext_wdata),
      .rd_en   (nnext_re),
      .rd_addr (node_raddr),
      .rd_data (nnext_rdata)
   );

   tgq_free_list #(
      .CAPACITY (CAPACITY)
   ) u_free_list (
      .clock     (clock),
      .reset     (reset),
      .cmd       (fl_cmd),
      .push_node (fl_push_node),
      .node      (fl_node),
      .stat      (fl_stat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_cnt_ff     <= '0;
         order_head_ff  <= '0;
         order_tail_ff  <= '0;
         order_count_ff <= '0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_cnt_ff     <= clr_cnt_in;
         order_head_ff  <= order_head_in;
         order_tail_ff  <= order_tail_in;
         order_count_ff <= order_count_in;
         rsp_strobe_ff  <= rsp_strobe_in;
      end
      elem_ff        <= elem_in;
      team_ff        <= team_in;
      tail_ff        <= tail_in;
      last_ff        <= last_in;
      rsp_valid_ff   <= rsp_valid_in;
      rsp_element_ff <= rsp_element_in;
      rsp_status_ff  <= rsp_status_in;
   end

endmodule

FILE: hdl/tgq_ram.sv
// Simple dual-port synchronous RAM with one write port and a registered read port.
module tgq_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 10,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

FILE: hdl/tgq_free_list.sv
// Free-node stack with a low-water mark so that slots never written read as their own index.
module tgq_free_list import tgq_pkg::*; #(
   parameter int CAPACITY = 1024,
   localparam int NW = $clog2(CAPACITY),
   localparam int CW = $clog2(CAPACITY + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  tgq_free_cmd_type  cmd,
   input  logic [NW-1:0]     push_node,
   output logic [NW-1:0]     node,
   output tgq_free_stat_type stat
);

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] low_ff, low_in;
   logic [CW-1:0] top_cw;
   logic [NW-1:0] slot_ff, slot_in;
   logic          fresh_ff, fresh_in;
   logic [NW-1:0] rd_data;
   logic          wr_en;

   assign top_cw     = count_ff - CW'(1);
   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == CW'(CAPACITY));
   assign node       = fresh_ff ? slot_ff : rd_data;

   always_comb begin
      count_in = count_ff;
      low_in   = low_ff;
      slot_in  = slot_ff;
      fresh_in = fresh_ff;
      wr_en    = 1'b0;
      if (cmd.peek) begin
         slot_in  = top_cw[NW-1:0];
         fresh_in = (top_cw < low_ff);
      end
      if (cmd.pop) begin
         count_in = top_cw;
         if (top_cw < low_ff) begin
            low_in = top_cw;
         end
      end
      if (cmd.push && !stat.full) begin
         wr_en    = 1'b1;
         count_in = count_ff + CW'(1);
      end
   end

   tgq_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (NW)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[NW-1:0]),
      .wr_data (push_node),
      .rd_en   (cmd.peek),
      .rd_addr (top_cw[NW-1:0]),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CW'(CAPACITY);
         low_ff   <= CW'(CAPACITY);
         fresh_ff <= 1'b1;
      end else begin
         count_ff <= count_in;
         low_ff   <= low_in;
         fresh_ff <= fresh_in;
      end
      slot_ff <= slot_in;
   end

endmodule

FILE: hdl/tgq_checker.sv
// Port-level checks for the team queue, bound to the top level.
module tgq_checker import tgq_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            start,
   input logic            busy,
   input logic [1:0]      req_type,
   input logic [ID_W-1:0] req_element_id,
   input logic [ID_W-1:0] req_team_id,
   input logic            rsp_strobe,
   input logic            rsp_out_valid,
   input logic [ID_W-1:0] rsp_out_element,
   input logic [1:0]      rsp_status
);

   logic accept;

   assign accept = start && !busy;

   // an accepted transaction either answers at once or holds the block busy
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy || rsp_strobe))
      else $error("accepted transaction neither answered nor held busy");

   // assign needs no memory walk and answers ok in the next cycle
   a_assign_latency: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_type == REQ_ASSIGN)) |=>
         (rsp_strobe && (rsp_status == STAT_OK) && !rsp_out_valid))
      else $error("assign did not answer ok in the next cycle");

   // an empty-queue status comes only right after a dequeue was taken
   a_empty_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == STAT_EMPTY)) |->
         $past(accept && (req_type == REQ_DEQUEUE)))
      else $error("empty status without a preceding dequeue");

   // a result needs a transaction taken or in progress in the previous cycle
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(busy) || $past(start)))
      else $error("result strobe without a transaction");

endmodule

bind team_grouped_queue tgq_checker u_tgq_checker (.*);
